>>> rtl/assert_macros.svh
// Assertion macros used by the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPL(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
	else $error("assertion failed: lbl");
`define ASSERT_NEXT(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
	else $error("assertion failed: lbl");
`else
`define ASSERT_IMPL(lbl, clk, rst_n, a, b)
`define ASSERT_NEXT(lbl, clk, rst_n, a, b)
`endif
`endif

>>> rtl/snew_pkg.sv
// Shared constants, codes and command/status types of the erase-before-write sequencer.
package snew_pkg;
	localparam int SECTOR_BYTES    = 4096;
	localparam int PAGE_BYTES      = 256;
	localparam int BUSY_POLL_LIMIT = 1000;
	localparam int SEC_W  = $clog2(SECTOR_BYTES);
	localparam int CNT_W  = SEC_W + 1;
	localparam int PG_W   = $clog2(PAGE_BYTES);
	localparam int PGC_W  = PG_W + 1;
	localparam int BUSY_W = 16;

	localparam logic [7:0] OP_READ   = 8'h03;
	localparam logic [7:0] OP_WREN   = 8'h06;
	localparam logic [7:0] OP_SERASE = 8'h20;
	localparam logic [7:0] OP_PROG   = 8'h02;
	localparam logic [7:0] OP_RDSR   = 8'h05;
	localparam logic [7:0] BYTE_ERASED = 8'hFF;

	localparam logic [1:0] REQ_HOST = 2'd0;
	localparam logic [1:0] REQ_HBYTE = 2'd1;
	localparam logic [1:0] REQ_XFER = 2'd2;
	localparam logic [1:0] REQ_TICK = 2'd3;

	localparam logic [1:0] CMD_WRITE = 2'd0;
	localparam logic [1:0] CMD_READ  = 2'd1;
	localparam logic [1:0] CMD_ERASE = 2'd2;

	localparam logic [2:0] ACT_SEND = 3'd0;
	localparam logic [2:0] ACT_RECV = 3'd1;
	localparam logic [2:0] ACT_HREQ = 3'd2;
	localparam logic [2:0] ACT_DELIV = 3'd3;
	localparam logic [2:0] ACT_WAIT = 3'd4;
	localparam logic [2:0] ACT_DONE = 3'd5;

	localparam logic [1:0] CTX_WREN  = 2'd0;
	localparam logic [1:0] CTX_ERASE = 2'd1;
	localparam logic [1:0] CTX_PROG  = 2'd2;

	localparam logic [7:0] REG_AREA = 8'd0;

	typedef enum logic [4:0] {
		K_NONE, K_RD_OP, K_RD_ADDR, K_RX, K_DELIV, K_DONE0, K_DONE1, K_SR_ADDR,
		K_SR_RX, K_HREQ, K_WREN, K_WAIT, K_SE_OP, K_ER_ADDR, K_PG_OP, K_PG_ADDR,
		K_PG_DATA, K_RDSR, K_POLL_RX
	} kind_t;

	typedef enum logic [1:0] {A_KEEP, A_IN, A_SECT, A_ADV} addr_op_t;
	typedef enum logic [2:0] {L_KEEP, L_IN, L_ZERO, L_DEC, L_SUB} left_op_t;
	typedef enum logic [1:0] {X_KEEP, X_ZERO, X_INC} cnt_op_t;
	typedef enum logic [1:0] {F_KEEP, F_SET, F_CLR} flag_op_t;

	typedef struct packed {
		addr_op_t   addr_op;
		left_op_t   left_op;
		logic       sect_start;
		logic       soff_zero;
		cnt_op_t    bcnt_op;
		cnt_op_t    cidx_op;
		logic       page_ld;
		logic       page_dec;
		logic       erase_chk;
		flag_op_t   retry_op;
		logic       busy_ld;
		logic       busy_dec;
		logic       ctx_ld;
		logic [1:0] ctx;
		logic       mem_we;
		logic       mem_host;
		kind_t      res;
		logic       res_stb;
		logic       res_last;
	} cmd_t;

	typedef struct packed {
		logic [1:0] typ;
		logic [1:0] cmd;
		logic       len_zero;
		logic       d0;
		logic       cidx3;
		logic       left_one;
		logic       left_zero;
		logic       left_eq_span;
		logic       bnext_lt_sector;
		logic       bnext_lt_span;
		logic       bcnt_lt_plen;
		logic       erase;
		logic       page_one;
		logic       busy_le1;
		logic       retry;
		logic [1:0] ctx;
	} stat_t;

	function automatic logic [7:0] cmd_byte(input logic [7:0] op, input logic [23:0] a,
		input logic [1:0] idx);
		case (idx)
			2'd0: cmd_byte = op;
			2'd1: cmd_byte = a[23:16];
			2'd2: cmd_byte = a[15:8];
			default: cmd_byte = a[7:0];
		endcase
	endfunction
endpackage

>>> rtl/snew_datapath.sv
// Datapath: input latch, address and byte counters, sector buffer and result formatter.
module snew_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  logic [1:0]           req_type,
	input  logic [1:0]           command,
	input  logic [23:0]          address,
	input  logic [15:0]          length,
	input  logic [7:0]           data_byte,
	input  logic [7:0]           area,
	input  snew_pkg::cmd_t       ctl,
	output snew_pkg::stat_t      st,
	output logic                 result_valid,
	output logic [2:0]           action,
	output logic                 select_before,
	output logic                 deselect_after,
	output logic                 chip,
	output logic [7:0]           byte_value,
	output logic                 status,
	output logic                 last
);
	logic [1:0]  typ_q, cmd_q;
	logic [23:0] in_addr_q;
	logic [15:0] in_len_q;
	logic [7:0]  in_d_q;

	logic [23:0] addr_q, addr_d;
	logic [15:0] left_q, left_d;
	logic [snew_pkg::SEC_W-1:0] soff_q, soff_d;
	logic [snew_pkg::CNT_W-1:0] span_q, span_d, bcnt_q, bcnt_d, room, plen, pleft;
	logic [snew_pkg::PGC_W-1:0] page_q, page_d, page_room;
	logic        erase_q, erase_d, retry_q;
	logic [1:0]  cidx_q, ctx_q;
	logic [snew_pkg::BUSY_W-1:0] busy_q;
	logic [23:0] base, pstart, paddr_cur, pnext;
	logic [snew_pkg::CNT_W-1:0] boff, ridx, widx;
	logic [7:0]  mem [snew_pkg::SECTOR_BYTES];
	logic [7:0]  rd_q;
	logic        in_span;

	// Latch the accepted beat
	always_ff @(posedge clk) begin
		if (accept) begin
			typ_q     <= req_type;
			cmd_q     <= command;
			in_addr_q <= address;
			in_len_q  <= length;
			in_d_q    <= data_byte;
		end
	end

	// Derived addresses
	assign base      = addr_q - 24'(soff_q);
	assign pstart    = erase_q ? base : addr_q;
	assign plen      = erase_q ? snew_pkg::CNT_W'(snew_pkg::SECTOR_BYTES) : span_q;
	assign boff      = erase_q ? '0 : snew_pkg::CNT_W'(soff_q);
	assign paddr_cur = pstart + 24'(bcnt_q);

	// Next values of the working registers
	always_comb begin
		case (ctl.addr_op)
			snew_pkg::A_IN:   addr_d = in_addr_q;
			snew_pkg::A_SECT: addr_d = 24'(in_addr_q << snew_pkg::SEC_W);
			snew_pkg::A_ADV:  addr_d = addr_q + 24'(span_q);
			default:          addr_d = addr_q;
		endcase
		case (ctl.left_op)
			snew_pkg::L_IN:   left_d = in_len_q;
			snew_pkg::L_ZERO: left_d = '0;
			snew_pkg::L_DEC:  left_d = left_q - 16'd1;
			snew_pkg::L_SUB:  left_d = left_q - 16'(span_q);
			default:          left_d = left_q;
		endcase
		soff_d = ctl.sect_start ? addr_d[snew_pkg::SEC_W-1:0] :
			(ctl.soff_zero ? '0 : soff_q);
		room = snew_pkg::CNT_W'(snew_pkg::SECTOR_BYTES) - snew_pkg::CNT_W'(soff_d);
		if (ctl.sect_start)
			span_d = (left_d < 16'(room)) ? snew_pkg::CNT_W'(left_d) : room;
		else
			span_d = span_q;
		in_span = (bcnt_q >= snew_pkg::CNT_W'(soff_q)) &&
			((bcnt_q - snew_pkg::CNT_W'(soff_q)) < span_q) && (in_d_q != snew_pkg::BYTE_ERASED);
		if (ctl.sect_start)
			erase_d = 1'b0;
		else if (ctl.erase_chk && in_span)
			erase_d = 1'b1;
		else
			erase_d = erase_q;
		case (ctl.bcnt_op)
			snew_pkg::X_ZERO: bcnt_d = '0;
			snew_pkg::X_INC:  bcnt_d = bcnt_q + 1'b1;
			default:          bcnt_d = bcnt_q;
		endcase
		pnext     = pstart + 24'(bcnt_d);
		page_room = snew_pkg::PGC_W'(snew_pkg::PAGE_BYTES) -
			snew_pkg::PGC_W'(pnext[snew_pkg::PG_W-1:0]);
		pleft     = plen - bcnt_d;
		if (ctl.page_ld)
			page_d = (pleft < snew_pkg::CNT_W'(page_room)) ? snew_pkg::PGC_W'(pleft) : page_room;
		else if (ctl.page_dec)
			page_d = page_q - 1'b1;
		else
			page_d = page_q;
	end

	// Hold the working registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q  <= '0;
			left_q  <= '0;
			soff_q  <= '0;
			span_q  <= '0;
			bcnt_q  <= '0;
			page_q  <= '0;
			erase_q <= 1'b0;
			retry_q <= 1'b0;
			busy_q  <= '0;
			cidx_q  <= '0;
			ctx_q   <= '0;
		end else begin
			addr_q  <= addr_d;
			left_q  <= left_d;
			soff_q  <= soff_d;
			span_q  <= span_d;
			bcnt_q  <= bcnt_d;
			page_q  <= page_d;
			erase_q <= erase_d;
			case (ctl.cidx_op)
				snew_pkg::X_ZERO: cidx_q <= '0;
				snew_pkg::X_INC:  cidx_q <= cidx_q + 1'b1;
				default:          cidx_q <= cidx_q;
			endcase
			case (ctl.retry_op)
				snew_pkg::F_SET: retry_q <= 1'b1;
				snew_pkg::F_CLR: retry_q <= 1'b0;
				default:         retry_q <= retry_q;
			endcase
			if (ctl.busy_ld)
				busy_q <= snew_pkg::BUSY_W'(snew_pkg::BUSY_POLL_LIMIT);
			else if (ctl.busy_dec && busy_q != '0)
				busy_q <= busy_q - 1'b1;
			if (ctl.ctx_ld)
				ctx_q <= ctl.ctx;
		end
	end

	// Sector buffer: one write port, one registered read port
	assign widx = ctl.mem_host ? (snew_pkg::CNT_W'(soff_q) + bcnt_q) : bcnt_q;
	assign ridx = boff + bcnt_q;
	always_ff @(posedge clk) begin
		if (ctl.mem_we && !widx[snew_pkg::SEC_W])
			mem[widx[snew_pkg::SEC_W-1:0]] <= in_d_q;
		rd_q <= mem[ridx[snew_pkg::SEC_W-1:0]];
	end

	// Status toward the controller
	always_comb begin
		st.typ             = typ_q;
		st.cmd             = cmd_q;
		st.len_zero        = (in_len_q == '0);
		st.d0              = in_d_q[0];
		st.cidx3           = (cidx_q == 2'd3);
		st.left_one        = (left_q == 16'd1);
		st.left_zero       = (left_q == '0);
		st.left_eq_span    = (left_q == 16'(span_q));
		st.bnext_lt_sector = ((bcnt_q + 1'b1) < snew_pkg::CNT_W'(snew_pkg::SECTOR_BYTES));
		st.bnext_lt_span   = ((bcnt_q + 1'b1) < span_q);
		st.bcnt_lt_plen    = (bcnt_q < plen);
		st.erase           = erase_q;
		st.page_one        = (page_q == snew_pkg::PGC_W'(1));
		st.busy_le1        = (busy_q <= snew_pkg::BUSY_W'(1));
		st.retry           = retry_q;
		st.ctx             = ctx_q;
	end

	// Format the result beat
	always_comb begin
		result_valid   = ctl.res_stb;
		last           = ctl.res_last;
		chip           = !(area == 8'd0 || area == 8'd2);
		action         = snew_pkg::ACT_SEND;
		select_before  = 1'b0;
		deselect_after = 1'b0;
		byte_value     = '0;
		status         = 1'b0;
		case (ctl.res)
			snew_pkg::K_RD_OP: begin
				select_before = 1'b1;
				byte_value    = snew_pkg::OP_READ;
			end
			snew_pkg::K_RD_ADDR: byte_value = snew_pkg::cmd_byte(snew_pkg::OP_READ, addr_q, cidx_q);
			snew_pkg::K_RX: begin
				action         = snew_pkg::ACT_RECV;
				deselect_after = (left_q == 16'd1);
			end
			snew_pkg::K_DELIV: begin
				action     = snew_pkg::ACT_DELIV;
				byte_value = in_d_q;
			end
			snew_pkg::K_DONE0: action = snew_pkg::ACT_DONE;
			snew_pkg::K_DONE1: begin
				action = snew_pkg::ACT_DONE;
				status = 1'b1;
			end
			snew_pkg::K_SR_ADDR: byte_value = snew_pkg::cmd_byte(snew_pkg::OP_READ, base, cidx_q);
			snew_pkg::K_SR_RX: begin
				action         = snew_pkg::ACT_RECV;
				deselect_after = (bcnt_q == snew_pkg::CNT_W'(snew_pkg::SECTOR_BYTES - 1));
			end
			snew_pkg::K_HREQ: action = snew_pkg::ACT_HREQ;
			snew_pkg::K_WREN: begin
				select_before  = 1'b1;
				deselect_after = 1'b1;
				byte_value     = snew_pkg::OP_WREN;
			end
			snew_pkg::K_WAIT: action = snew_pkg::ACT_WAIT;
			snew_pkg::K_SE_OP: begin
				select_before = 1'b1;
				byte_value    = snew_pkg::OP_SERASE;
			end
			snew_pkg::K_ER_ADDR: begin
				deselect_after = (cidx_q == 2'd3);
				byte_value     = snew_pkg::cmd_byte(snew_pkg::OP_SERASE, base, cidx_q);
			end
			snew_pkg::K_PG_OP: begin
				select_before = 1'b1;
				byte_value    = snew_pkg::OP_PROG;
			end
			snew_pkg::K_PG_ADDR: byte_value = snew_pkg::cmd_byte(snew_pkg::OP_PROG, paddr_cur, cidx_q);
			snew_pkg::K_PG_DATA: begin
				deselect_after = (page_q == snew_pkg::PGC_W'(1));
				byte_value     = ridx[snew_pkg::SEC_W] ? 8'd0 : rd_q;
			end
			snew_pkg::K_RDSR: begin
				select_before = 1'b1;
				byte_value    = snew_pkg::OP_RDSR;
			end
			snew_pkg::K_POLL_RX: begin
				action         = snew_pkg::ACT_RECV;
				deselect_after = 1'b1;
			end
			default: action = snew_pkg::ACT_SEND;
		endcase
	end
endmodule

>>> rtl/snew_ctrl.sv
// Controller: flash phase machine and result sequencing.
module snew_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            accept,
	input  snew_pkg::stat_t st,
	output snew_pkg::cmd_t  ctl,
	output logic            busy
);
	typedef enum logic [3:0] {
		PH_IDLE, PH_RD_CMD, PH_RD_DATA, PH_SR_CMD, PH_SR_DATA, PH_HOST, PH_ER_WE,
		PH_ER_CMD, PH_PG_WE, PH_PG_CMD, PH_PG_DATA, PH_POLL_WAIT, PH_POLL_CMD, PH_POLL_RX
	} phase_t;
	typedef enum logic [2:0] {S_IDLE, S_EXEC, S_PREP, S_EMIT1, S_EMIT2} seq_t;

	phase_t phase_q, ph_d;
	seq_t   seq_q;
	snew_pkg::kind_t res1_q, res2_q, r1, r2;
	snew_pkg::cmd_t  c;

	assign busy = (seq_q != S_IDLE);

	// Step the phase machine on one latched beat
	always_comb begin
		c = '0;
		c.addr_op = snew_pkg::A_KEEP;
		c.left_op = snew_pkg::L_KEEP;
		c.bcnt_op = snew_pkg::X_KEEP;
		c.cidx_op = snew_pkg::X_KEEP;
		c.retry_op = snew_pkg::F_KEEP;
		c.res = snew_pkg::K_NONE;
		ph_d = phase_q;
		r1 = snew_pkg::K_NONE;
		r2 = snew_pkg::K_NONE;
		case (phase_q)
			PH_IDLE: begin
				if (st.typ == snew_pkg::REQ_HOST) begin
					if (st.cmd == snew_pkg::CMD_ERASE) begin
						c.addr_op  = snew_pkg::A_SECT;
						c.soff_zero = 1'b1;
						c.left_op  = snew_pkg::L_ZERO;
						c.retry_op = snew_pkg::F_SET;
						ph_d = PH_ER_WE;
						r1 = snew_pkg::K_WREN;
					end else if ((st.cmd == snew_pkg::CMD_WRITE || st.cmd == snew_pkg::CMD_READ)
						&& !st.len_zero) begin
						c.addr_op = snew_pkg::A_IN;
						c.left_op = snew_pkg::L_IN;
						c.cidx_op = snew_pkg::X_ZERO;
						r1 = snew_pkg::K_RD_OP;
						if (st.cmd == snew_pkg::CMD_WRITE) begin
							c.sect_start = 1'b1;
							c.bcnt_op = snew_pkg::X_ZERO;
							ph_d = PH_SR_CMD;
						end else
							ph_d = PH_RD_CMD;
					end else
						r1 = snew_pkg::K_DONE1;
				end
			end
			PH_RD_CMD: if (st.typ == snew_pkg::REQ_XFER) begin
				c.cidx_op = snew_pkg::X_INC;
				if (!st.cidx3)
					r1 = snew_pkg::K_RD_ADDR;
				else begin
					ph_d = PH_RD_DATA;
					r1 = snew_pkg::K_RX;
				end
			end
			PH_RD_DATA: if (st.typ == snew_pkg::REQ_XFER) begin
				c.left_op = snew_pkg::L_DEC;
				r1 = snew_pkg::K_DELIV;
				if (st.left_one) begin
					ph_d = PH_IDLE;
					r2 = snew_pkg::K_DONE0;
				end else
					r2 = snew_pkg::K_RX;
			end
			PH_SR_CMD: if (st.typ == snew_pkg::REQ_XFER) begin
				c.cidx_op = snew_pkg::X_INC;
				if (!st.cidx3)
					r1 = snew_pkg::K_SR_ADDR;
				else begin
					ph_d = PH_SR_DATA;
					c.bcnt_op = snew_pkg::X_ZERO;
					r1 = snew_pkg::K_SR_RX;
				end
			end
			PH_SR_DATA: if (st.typ == snew_pkg::REQ_XFER) begin
				c.mem_we = 1'b1;
				c.erase_chk = 1'b1;
				if (st.bnext_lt_sector) begin
					c.bcnt_op = snew_pkg::X_INC;
					r1 = snew_pkg::K_SR_RX;
				end else begin
					c.bcnt_op = snew_pkg::X_ZERO;
					ph_d = PH_HOST;
					r1 = snew_pkg::K_HREQ;
				end
			end
			PH_HOST: if (st.typ == snew_pkg::REQ_HBYTE) begin
				c.mem_we = 1'b1;
				c.mem_host = 1'b1;
				if (st.bnext_lt_span) begin
					c.bcnt_op = snew_pkg::X_INC;
					r1 = snew_pkg::K_HREQ;
				end else begin
					c.retry_op = snew_pkg::F_CLR;
					r1 = snew_pkg::K_WREN;
					if (st.erase) begin
						c.bcnt_op = snew_pkg::X_INC;
						ph_d = PH_ER_WE;
					end else begin
						c.bcnt_op = snew_pkg::X_ZERO;
						c.page_ld = 1'b1;
						ph_d = PH_PG_WE;
					end
				end
			end
			PH_ER_WE: if (st.typ == snew_pkg::REQ_XFER) begin
				c.ctx_ld = 1'b1;
				c.ctx = snew_pkg::CTX_WREN;
				c.busy_ld = 1'b1;
				ph_d = PH_POLL_WAIT;
				r1 = snew_pkg::K_WAIT;
			end
			PH_ER_CMD: if (st.typ == snew_pkg::REQ_XFER) begin
				c.cidx_op = snew_pkg::X_INC;
				if (!st.cidx3)
					r1 = snew_pkg::K_ER_ADDR;
				else begin
					c.ctx_ld = 1'b1;
					c.ctx = snew_pkg::CTX_ERASE;
					c.busy_ld = 1'b1;
					ph_d = PH_POLL_WAIT;
					r1 = snew_pkg::K_WAIT;
				end
			end
			PH_PG_WE: if (st.typ == snew_pkg::REQ_XFER) begin
				c.cidx_op = snew_pkg::X_ZERO;
				ph_d = PH_PG_CMD;
				r1 = snew_pkg::K_PG_OP;
			end
			PH_PG_CMD: if (st.typ == snew_pkg::REQ_XFER) begin
				c.cidx_op = snew_pkg::X_INC;
				if (!st.cidx3)
					r1 = snew_pkg::K_PG_ADDR;
				else begin
					ph_d = PH_PG_DATA;
					r1 = snew_pkg::K_PG_DATA;
				end
			end
			PH_PG_DATA: if (st.typ == snew_pkg::REQ_XFER) begin
				c.bcnt_op = snew_pkg::X_INC;
				c.page_dec = 1'b1;
				if (!st.page_one)
					r1 = snew_pkg::K_PG_DATA;
				else begin
					c.ctx_ld = 1'b1;
					c.ctx = snew_pkg::CTX_PROG;
					c.busy_ld = 1'b1;
					ph_d = PH_POLL_WAIT;
					r1 = snew_pkg::K_WAIT;
				end
			end
			PH_POLL_WAIT: if (st.typ == snew_pkg::REQ_TICK) begin
				ph_d = PH_POLL_CMD;
				r1 = snew_pkg::K_RDSR;
			end
			PH_POLL_CMD: if (st.typ == snew_pkg::REQ_XFER) begin
				ph_d = PH_POLL_RX;
				r1 = snew_pkg::K_POLL_RX;
			end
			PH_POLL_RX: if (st.typ == snew_pkg::REQ_XFER) begin
				if (st.d0 && !st.busy_le1) begin
					c.busy_dec = 1'b1;
					ph_d = PH_POLL_WAIT;
					r1 = snew_pkg::K_WAIT;
				end else if (!st.d0) begin
					// device ready: move on
					if (st.ctx == snew_pkg::CTX_WREN) begin
						c.cidx_op = snew_pkg::X_ZERO;
						ph_d = PH_ER_CMD;
						r1 = snew_pkg::K_SE_OP;
					end else if (st.ctx == snew_pkg::CTX_ERASE) begin
						if (st.left_zero) begin
							ph_d = PH_IDLE;
							r1 = snew_pkg::K_DONE0;
						end else begin
							c.retry_op = snew_pkg::F_CLR;
							c.bcnt_op = snew_pkg::X_ZERO;
							c.page_ld = 1'b1;
							ph_d = PH_PG_WE;
							r1 = snew_pkg::K_WREN;
						end
					end else if (st.bcnt_lt_plen) begin
						c.page_ld = 1'b1;
						ph_d = PH_PG_WE;
						r1 = snew_pkg::K_WREN;
					end else if (st.left_eq_span) begin
						c.addr_op = snew_pkg::A_ADV;
						c.left_op = snew_pkg::L_SUB;
						ph_d = PH_IDLE;
						r1 = snew_pkg::K_DONE0;
					end else begin
						c.addr_op = snew_pkg::A_ADV;
						c.left_op = snew_pkg::L_SUB;
						c.sect_start = 1'b1;
						c.bcnt_op = snew_pkg::X_ZERO;
						c.cidx_op = snew_pkg::X_ZERO;
						ph_d = PH_SR_CMD;
						r1 = snew_pkg::K_RD_OP;
					end
				end else begin
					// timeout: fail if already retried, else retry
					c.busy_dec = 1'b1;
					if (st.retry) begin
						ph_d = PH_IDLE;
						r1 = snew_pkg::K_DONE1;
					end else begin
						c.retry_op = snew_pkg::F_SET;
						r1 = snew_pkg::K_WREN;
						if (st.ctx == snew_pkg::CTX_PROG) begin
							c.bcnt_op = snew_pkg::X_ZERO;
							c.page_ld = 1'b1;
							ph_d = PH_PG_WE;
						end else
							ph_d = PH_ER_WE;
					end
				end
			end
			default: ph_d = PH_IDLE;
		endcase
		if (r1 == snew_pkg::K_DONE1)
			ph_d = PH_IDLE;
	end

	// Drive the datapath: step only in the execute cycle, results in emit cycles
	always_comb begin
		if (seq_q == S_EXEC)
			ctl = c;
		else begin
			ctl = '0;
			ctl.addr_op = snew_pkg::A_KEEP;
			ctl.left_op = snew_pkg::L_KEEP;
			ctl.bcnt_op = snew_pkg::X_KEEP;
			ctl.cidx_op = snew_pkg::X_KEEP;
			ctl.retry_op = snew_pkg::F_KEEP;
			ctl.res = snew_pkg::K_NONE;
			if (seq_q == S_EMIT1) begin
				ctl.res = res1_q;
				ctl.res_stb = 1'b1;
				ctl.res_last = (res2_q == snew_pkg::K_NONE);
			end else if (seq_q == S_EMIT2) begin
				ctl.res = res2_q;
				ctl.res_stb = 1'b1;
				ctl.res_last = 1'b1;
			end
		end
	end

	// Hold phase, sequencer state and pending results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			seq_q   <= S_IDLE;
			res1_q  <= snew_pkg::K_NONE;
			res2_q  <= snew_pkg::K_NONE;
		end else begin
			case (seq_q)
				S_IDLE: if (accept) seq_q <= S_EXEC;
				S_EXEC: begin
					phase_q <= ph_d;
					res1_q  <= r1;
					res2_q  <= r2;
					seq_q   <= (r1 == snew_pkg::K_NONE) ? S_IDLE : S_PREP;
				end
				S_PREP:  seq_q <= S_EMIT1;
				S_EMIT1: seq_q <= (res2_q == snew_pkg::K_NONE) ? S_IDLE : S_EMIT2;
				S_EMIT2: seq_q <= S_IDLE;
				default: seq_q <= S_IDLE;
			endcase
		end
	end
endmodule

>>> rtl/spi_nor_erase_before_write_sequencer_core.sv
// Top level of the SPI NOR erase-before-write sequencer: config port, controller, datapath.
//
//  channel  | handshake                            | payload
//  ---------+--------------------------------------+------------------------------------------
//  input    | start & !busy                        | req_type command address length data_byte
//  result   | result_valid (one cycle, no stall)   | action select_before deselect_after chip
//           |                                      | byte_value status last
//  config   | psel & penable & pwrite (pready = 1) | paddr pwdata -> firmware_area
//
// A beat that causes no result passes through latch and execute; one with results passes
// through latch, execute and buffer read, then emits each result beat. The phase
// machine steps once per beat; the buffer read step serves the sector buffer's registered
// read port. Reset clears control and counter state, not the input latch or the buffer.
// Results are strobed for one cycle and cannot be held off by the receiver.
`include "assert_macros.svh"
module spi_nor_erase_before_write_sequencer_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  req_type,
	input  logic [1:0]  command,
	input  logic [23:0] address,
	input  logic [15:0] length,
	input  logic [7:0]  data_byte,
	output logic        result_valid,
	output logic [2:0]  action,
	output logic        select_before,
	output logic        deselect_after,
	output logic        chip,
	output logic [7:0]  byte_value,
	output logic        status,
	output logic        last,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	logic [7:0] area_q;
	logic       accept;
	snew_pkg::cmd_t  ctl;
	snew_pkg::stat_t st;

	assign pready = 1'b1;
	assign accept = start && !busy;

	// Config register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			area_q <= '0;
		else if (psel && penable && pwrite && (8'(paddr[2]) == snew_pkg::REG_AREA))
			area_q <= pwdata[7:0];
	end
	assign prdata = (8'(paddr[2]) == snew_pkg::REG_AREA) ? {24'd0, area_q} : '0;

	snew_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.st     (st),
		.ctl    (ctl),
		.busy   (busy)
	);

	snew_datapath u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (accept),
		.req_type       (req_type),
		.command        (command),
		.address        (address),
		.length         (length),
		.data_byte      (data_byte),
		.area           (area_q),
		.ctl            (ctl),
		.st             (st),
		.result_valid   (result_valid),
		.action         (action),
		.select_before  (select_before),
		.deselect_after (deselect_after),
		.chip           (chip),
		.byte_value     (byte_value),
		.status         (status),
		.last           (last)
	);

	`ASSERT_IMPL(a_res_busy, clk, arst_n, result_valid, busy)
	`ASSERT_NEXT(a_acc_busy, clk, arst_n, accept, busy && !result_valid)
	`ASSERT_NEXT(a_last_idle, clk, arst_n, result_valid && last, !result_valid && !busy)
	`ASSERT_IMPL(a_mem_quiet, clk, arst_n, ctl.mem_we, !result_valid)
endmodule

>>> tb/spi_nor_erase_before_write_sequencer_core_tb.sv
// Self-checking testbench for the SPI NOR erase-before-write sequencer core.
`timescale 1ns / 1ps
module spi_nor_erase_before_write_sequencer_core_tb;
	localparam logic [1:0] CMD_UNKNOWN = 2'd3;
	localparam int STALL_LIMIT = 5000;
	localparam int RANDOM_OPS = 40;

	typedef enum logic [3:0] {
		S_IDLE, S_RD_CMD, S_RD_DATA, S_SR_CMD, S_SR_DATA, S_HOST, S_ER_WE, S_ER_CMD,
		S_PG_WE, S_PG_CMD, S_PG_DATA, S_POLL_WAIT, S_POLL_CMD, S_POLL_RX
	} seq_phase_t;

	typedef struct packed {
		logic [2:0] action;
		logic       sel;
		logic       desel;
		logic       chip;
		logic [7:0] value;
		logic       status;
		logic       last;
	} xfer_res_t;

	typedef struct packed {
		logic [1:0]  rt;
		logic [1:0]  cmd;
		logic [23:0] addr;
		logic [15:0] len;
		logic [7:0]  d;
		logic        typed;
		logic        st;
	} beat_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [1:0]  req_type = '0;
	logic [1:0]  command = '0;
	logic [23:0] address = '0;
	logic [15:0] length = '0;
	logic [7:0]  data_byte = '0;
	logic        result_valid;
	logic [2:0]  action;
	logic        select_before;
	logic        deselect_after;
	logic        chip;
	logic [7:0]  byte_value;
	logic        status;
	logic        last;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	spi_nor_erase_before_write_sequencer_core dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req_type(req_type), .command(command), .address(address), .length(length),
		.data_byte(data_byte), .result_valid(result_valid), .action(action),
		.select_before(select_before), .deselect_after(deselect_after), .chip(chip),
		.byte_value(byte_value), .status(status), .last(last),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #6 clk = ~clk;

	// Mirror of the sequencer state
	logic [7:0]  shadow_sector [snew_pkg::SECTOR_BYTES];
	seq_phase_t  seq_ph = S_IDLE;
	logic [23:0] cur_addr = '0;
	logic [15:0] bytes_left = '0;
	logic [11:0] sect_off = '0;
	logic [12:0] span_len = '0;
	logic [12:0] byte_cnt = '0;
	logic [8:0]  page_left = '0;
	logic        need_erase = 1'b0;
	logic        retried = 1'b0;
	logic [15:0] poll_budget = '0;
	logic [2:0]  op_idx = '0;
	logic [1:0]  poll_kind = '0;
	logic [7:0]  area_reg = '0;

	xfer_res_t   step_res[$];
	xfer_res_t   pending_results[$];
	int          fail_count = 0;
	int          idle_cycles = 0;
	bit          quiet = 1'b0;
	bit          force_busy = 1'b0;
	bit          erased_fill = 1'b0;

	function automatic logic area_chip();
		return (area_reg == 8'd0 || area_reg == 8'd2) ? 1'b0 : 1'b1;
	endfunction

	function automatic void emit(logic [2:0] act, logic s, logic ds, logic [7:0] v, logic st);
		xfer_res_t r;
		r = '{act, s, ds, area_chip(), v, st, 1'b0};
		step_res.push_back(r);
	endfunction

	function automatic logic [7:0] addr_byte(logic [7:0] op, logic [23:0] a, logic [2:0] idx);
		case (idx)
			3'd0: return op;
			3'd1: return a[23:16];
			3'd2: return a[15:8];
			default: return a[7:0];
		endcase
	endfunction

	function automatic logic [23:0] sect_base();
		return cur_addr - {12'd0, sect_off};
	endfunction

	function automatic logic [23:0] prog_base();
		return need_erase ? sect_base() : cur_addr;
	endfunction

	function automatic logic [12:0] prog_len();
		return need_erase ? 13'(snew_pkg::SECTOR_BYTES) : span_len;
	endfunction

	function automatic void end_op(logic st);
		seq_ph = S_IDLE;
		emit(snew_pkg::ACT_DONE, 1'b0, 1'b0, 8'h00, st);
	endfunction

	function automatic void begin_poll(logic [1:0] kind);
		poll_kind = kind;
		poll_budget = 16'(snew_pkg::BUSY_POLL_LIMIT);
		seq_ph = S_POLL_WAIT;
		emit(snew_pkg::ACT_WAIT, 1'b0, 1'b0, 8'h00, 1'b0);
	endfunction

	function automatic void begin_sector_read();
		logic [12:0] room;
		sect_off = cur_addr[11:0];
		room = 13'(snew_pkg::SECTOR_BYTES) - {1'b0, sect_off};
		span_len = (bytes_left < {3'd0, room}) ? bytes_left[12:0] : room;
		need_erase = 1'b0;
		byte_cnt = '0;
		op_idx = '0;
		seq_ph = S_SR_CMD;
		emit(snew_pkg::ACT_SEND, 1'b1, 1'b0, snew_pkg::OP_READ, 1'b0);
	endfunction

	function automatic void begin_erase();
		seq_ph = S_ER_WE;
		emit(snew_pkg::ACT_SEND, 1'b1, 1'b1, snew_pkg::OP_WREN, 1'b0);
	endfunction

	function automatic void open_page();
		logic [23:0] a;
		logic [12:0] rem;
		a = prog_base() + {11'd0, byte_cnt};
		rem = prog_len() - byte_cnt;
		page_left = 9'(snew_pkg::PAGE_BYTES) - {1'b0, a[7:0]};
		if (rem < {4'd0, page_left}) page_left = rem[8:0];
		seq_ph = S_PG_WE;
		emit(snew_pkg::ACT_SEND, 1'b1, 1'b1, snew_pkg::OP_WREN, 1'b0);
	endfunction

	function automatic void send_page_byte();
		logic [12:0] i;
		i = (need_erase ? 13'd0 : {1'b0, sect_off}) + byte_cnt;
		emit(snew_pkg::ACT_SEND, 1'b0, page_left == 9'd1,
			(i < 13'(snew_pkg::SECTOR_BYTES)) ? shadow_sector[i[11:0]] : 8'h00, 1'b0);
	endfunction

	function automatic void erase_fail();
		if (!retried) begin
			retried = 1'b1;
			begin_erase();
		end else begin
			end_op(1'b1);
		end
	endfunction

	function automatic void poll_result(bit ok);
		if (poll_kind == snew_pkg::CTX_WREN) begin
			if (!ok) begin
				erase_fail();
				return;
			end
			seq_ph = S_ER_CMD;
			op_idx = '0;
			emit(snew_pkg::ACT_SEND, 1'b1, 1'b0, snew_pkg::OP_SERASE, 1'b0);
		end else if (poll_kind == snew_pkg::CTX_ERASE) begin
			if (!ok) begin
				erase_fail();
				return;
			end
			if (bytes_left == 16'd0) begin
				end_op(1'b0);
			end else begin
				retried = 1'b0;
				byte_cnt = '0;
				open_page();
			end
		end else begin
			if (!ok) begin
				if (!retried) begin
					retried = 1'b1;
					byte_cnt = '0;
					open_page();
				end else begin
					end_op(1'b1);
				end
				return;
			end
			if (byte_cnt < prog_len()) begin
				open_page();
			end else begin
				// advance to the next sector of the range
				cur_addr = cur_addr + {11'd0, span_len};
				bytes_left = bytes_left - {3'd0, span_len};
				if (bytes_left == 16'd0) end_op(1'b0);
				else begin_sector_read();
			end
		end
	endfunction

	// Predict the results of one accepted beat; keep=0 drops them
	task automatic predict_beat(input logic [1:0] rt, input logic [1:0] cmd,
		input logic [23:0] a, input logic [15:0] len, input logic [7:0] d, input bit keep);
		step_res.delete();
		case (seq_ph)
			S_IDLE: if (rt == snew_pkg::REQ_HOST) begin
				if (cmd == snew_pkg::CMD_WRITE || cmd == snew_pkg::CMD_READ) begin
					if (len == 16'd0) begin
						end_op(1'b1);
					end else begin
						cur_addr = a;
						bytes_left = len;
						if (cmd == snew_pkg::CMD_WRITE) begin
							begin_sector_read();
						end else begin
							op_idx = '0;
							seq_ph = S_RD_CMD;
							emit(snew_pkg::ACT_SEND, 1'b1, 1'b0, snew_pkg::OP_READ, 1'b0);
						end
					end
				end else if (cmd == snew_pkg::CMD_ERASE) begin
					cur_addr = {a[11:0], 12'd0};
					sect_off = '0;
					bytes_left = '0;
					retried = 1'b1;
					begin_erase();
				end else begin
					end_op(1'b1);
				end
			end
			S_RD_CMD: if (rt == snew_pkg::REQ_XFER) begin
				op_idx++;
				if (op_idx < 3'd4) begin
					emit(snew_pkg::ACT_SEND, 1'b0, 1'b0,
						addr_byte(snew_pkg::OP_READ, cur_addr, op_idx), 1'b0);
				end else begin
					seq_ph = S_RD_DATA;
					emit(snew_pkg::ACT_RECV, 1'b0, bytes_left == 16'd1, 8'h00, 1'b0);
				end
			end
			S_RD_DATA: if (rt == snew_pkg::REQ_XFER) begin
				emit(snew_pkg::ACT_DELIV, 1'b0, 1'b0, d, 1'b0);
				bytes_left--;
				if (bytes_left == 16'd0) end_op(1'b0);
				else emit(snew_pkg::ACT_RECV, 1'b0, bytes_left == 16'd1, 8'h00, 1'b0);
			end
			S_SR_CMD: if (rt == snew_pkg::REQ_XFER) begin
				op_idx++;
				if (op_idx < 3'd4) begin
					emit(snew_pkg::ACT_SEND, 1'b0, 1'b0,
						addr_byte(snew_pkg::OP_READ, sect_base(), op_idx), 1'b0);
				end else begin
					seq_ph = S_SR_DATA;
					byte_cnt = '0;
					emit(snew_pkg::ACT_RECV, 1'b0, 1'b0, 8'h00, 1'b0);
				end
			end
			S_SR_DATA: if (rt == snew_pkg::REQ_XFER) begin
				shadow_sector[byte_cnt[11:0]] = d;
				if (byte_cnt >= {1'b0, sect_off} && byte_cnt - {1'b0, sect_off} < span_len
					&& d != snew_pkg::BYTE_ERASED)
					need_erase = 1'b1;
				byte_cnt++;
				if (byte_cnt < 13'(snew_pkg::SECTOR_BYTES)) begin
					emit(snew_pkg::ACT_RECV, 1'b0,
						byte_cnt == 13'(snew_pkg::SECTOR_BYTES - 1), 8'h00, 1'b0);
				end else begin
					seq_ph = S_HOST;
					byte_cnt = '0;
					emit(snew_pkg::ACT_HREQ, 1'b0, 1'b0, 8'h00, 1'b0);
				end
			end
			S_HOST: if (rt == snew_pkg::REQ_HBYTE) begin
				shadow_sector[sect_off + byte_cnt[11:0]] = d;
				byte_cnt++;
				if (byte_cnt < span_len) begin
					emit(snew_pkg::ACT_HREQ, 1'b0, 1'b0, 8'h00, 1'b0);
				end else if (need_erase) begin
					retried = 1'b0;
					begin_erase();
				end else begin
					retried = 1'b0;
					byte_cnt = '0;
					open_page();
				end
			end
			S_ER_WE: if (rt == snew_pkg::REQ_XFER) begin_poll(snew_pkg::CTX_WREN);
			S_ER_CMD: if (rt == snew_pkg::REQ_XFER) begin
				op_idx++;
				if (op_idx < 3'd4)
					emit(snew_pkg::ACT_SEND, 1'b0, op_idx == 3'd3,
						addr_byte(snew_pkg::OP_SERASE, sect_base(), op_idx), 1'b0);
				else
					begin_poll(snew_pkg::CTX_ERASE);
			end
			S_PG_WE: if (rt == snew_pkg::REQ_XFER) begin
				seq_ph = S_PG_CMD;
				op_idx = '0;
				emit(snew_pkg::ACT_SEND, 1'b1, 1'b0, snew_pkg::OP_PROG, 1'b0);
			end
			S_PG_CMD: if (rt == snew_pkg::REQ_XFER) begin
				op_idx++;
				if (op_idx < 3'd4) begin
					emit(snew_pkg::ACT_SEND, 1'b0, 1'b0,
						addr_byte(snew_pkg::OP_PROG, prog_base() + {11'd0, byte_cnt}, op_idx),
						1'b0);
				end else begin
					seq_ph = S_PG_DATA;
					send_page_byte();
				end
			end
			S_PG_DATA: if (rt == snew_pkg::REQ_XFER) begin
				byte_cnt++;
				page_left--;
				if (page_left > 9'd0) send_page_byte();
				else begin_poll(snew_pkg::CTX_PROG);
			end
			S_POLL_WAIT: if (rt == snew_pkg::REQ_TICK) begin
				seq_ph = S_POLL_CMD;
				emit(snew_pkg::ACT_SEND, 1'b1, 1'b0, snew_pkg::OP_RDSR, 1'b0);
			end
			S_POLL_CMD: if (rt == snew_pkg::REQ_XFER) begin
				seq_ph = S_POLL_RX;
				emit(snew_pkg::ACT_RECV, 1'b0, 1'b1, 8'h00, 1'b0);
			end
			S_POLL_RX: if (rt == snew_pkg::REQ_XFER) begin
				if (!d[0]) begin
					poll_result(1'b1);
				end else begin
					if (poll_budget > 16'd0) poll_budget--;
					if (poll_budget == 16'd0) begin
						poll_result(1'b0);
					end else begin
						seq_ph = S_POLL_WAIT;
						emit(snew_pkg::ACT_WAIT, 1'b0, 1'b0, 8'h00, 1'b0);
					end
				end
			end
			default: seq_ph = S_IDLE;
		endcase
		if (step_res.size() > 0) step_res[step_res.size() - 1].last = 1'b1;
		if (keep) foreach (step_res[k]) pending_results.push_back(step_res[k]);
	endtask

	// Present one beat, wait until the core is idle again, then predict it
	task automatic send_beat(input logic [1:0] rt, input logic [1:0] cmd,
		input logic [23:0] a, input logic [15:0] len, input logic [7:0] d, input bit keep);
		if (!quiet && $urandom_range(0, 99) < 8) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		req_type <= rt;
		command <= cmd;
		address <= a;
		length <= len;
		data_byte <= d;
		start <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		predict_beat(rt, cmd, a, len, d, keep);
	endtask

	// Write the area register while the block is idle
	task automatic write_area(input logic [7:0] v);
		start <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= snew_pkg::REG_AREA[2:0];
		pwdata <= {24'd0, v};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		area_reg = v;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Answer the beat that the current phase awaits, with some noise
	task automatic service_op();
		logic [1:0] rt;
		logic [7:0] d;
		while (seq_ph != S_IDLE) begin
			d = 8'($urandom);
			case (seq_ph)
				S_HOST: rt = snew_pkg::REQ_HBYTE;
				S_POLL_WAIT: rt = snew_pkg::REQ_TICK;
				default: rt = snew_pkg::REQ_XFER;
			endcase
			if (seq_ph == S_SR_DATA)
				d = (erased_fill || $urandom_range(0, 3) != 0) ? snew_pkg::BYTE_ERASED : d;
			if (seq_ph == S_POLL_RX)
				d[0] = force_busy || $urandom_range(0, 99) < 25;
			if ($urandom_range(0, 99) < 5)
				send_beat(2'($urandom), 2'($urandom), 24'($urandom), 16'($urandom),
					8'($urandom), 1'b1);
			else
				send_beat(rt, 2'($urandom), 24'($urandom), 16'($urandom), d, 1'b1);
		end
	endtask

	beat_row_t directed_rows[] = '{
		'{snew_pkg::REQ_TICK,  snew_pkg::CMD_WRITE, 24'h000000, 16'h0000, 8'h00, 1'b0, 1'b0},
		'{snew_pkg::REQ_HBYTE, CMD_UNKNOWN,         24'hFFFFFF, 16'hFFFF, 8'hFF, 1'b0, 1'b0},
		'{snew_pkg::REQ_XFER,  snew_pkg::CMD_READ,  24'h5A5A5A, 16'h8000, 8'hA5, 1'b0, 1'b0},
		'{snew_pkg::REQ_HOST,  snew_pkg::CMD_WRITE, 24'h123456, 16'h0000, 8'h00, 1'b1, 1'b1},
		'{snew_pkg::REQ_HOST,  snew_pkg::CMD_READ,  24'hFFFFFF, 16'h0000, 8'h00, 1'b1, 1'b1},
		'{snew_pkg::REQ_HOST,  CMD_UNKNOWN,         24'h000000, 16'hFFFF, 8'h00, 1'b1, 1'b1},
		'{snew_pkg::REQ_HOST,  snew_pkg::CMD_READ,  24'hFFFFFF, 16'h0002, 8'h00, 1'b0, 1'b0},
		'{snew_pkg::REQ_HOST,  snew_pkg::CMD_ERASE, 24'h000001, 16'h0001, 8'h00, 1'b0, 1'b0},
		'{snew_pkg::REQ_XFER,  snew_pkg::CMD_WRITE, 24'h000000, 16'h0000, 8'h00, 1'b0, 1'b0},
		'{snew_pkg::REQ_XFER,  snew_pkg::CMD_WRITE, 24'h000000, 16'h0000, 8'h00, 1'b0, 1'b0},
		'{snew_pkg::REQ_XFER,  snew_pkg::CMD_WRITE, 24'h000000, 16'h0000, 8'h00, 1'b0, 1'b0},
		'{snew_pkg::REQ_XFER,  snew_pkg::CMD_WRITE, 24'h000000, 16'h0000, 8'h00, 1'b0, 1'b0},
		'{snew_pkg::REQ_XFER,  snew_pkg::CMD_WRITE, 24'h000000, 16'h0000, 8'h00, 1'b0, 1'b0},
		'{snew_pkg::REQ_XFER,  snew_pkg::CMD_WRITE, 24'h000000, 16'h0000, 8'hFF, 1'b0, 1'b0},
		'{snew_pkg::REQ_HOST,  snew_pkg::CMD_ERASE, 24'hFFFFFF, 16'hFFFF, 8'hFF, 1'b0, 1'b0},
		'{snew_pkg::REQ_XFER,  snew_pkg::CMD_WRITE, 24'h000000, 16'h0000, 8'h00, 1'b0, 1'b0},
		'{snew_pkg::REQ_XFER,  snew_pkg::CMD_WRITE, 24'h000000, 16'h0000, 8'h00, 1'b0, 1'b0},
		'{snew_pkg::REQ_TICK,  snew_pkg::CMD_WRITE, 24'h000000, 16'h0000, 8'h00, 1'b0, 1'b0},
		'{snew_pkg::REQ_XFER,  snew_pkg::CMD_WRITE, 24'h000000, 16'h0000, 8'h00, 1'b0, 1'b0},
		'{snew_pkg::REQ_XFER,  snew_pkg::CMD_WRITE, 24'h000000, 16'h0000, 8'h01, 1'b0, 1'b0},
		'{snew_pkg::REQ_TICK,  snew_pkg::CMD_WRITE, 24'h000000, 16'h0000, 8'h00, 1'b0, 1'b0},
		'{snew_pkg::REQ_XFER,  snew_pkg::CMD_WRITE, 24'h000000, 16'h0000, 8'h00, 1'b0, 1'b0},
		'{snew_pkg::REQ_XFER,  snew_pkg::CMD_WRITE, 24'h000000, 16'h0000, 8'hFE, 1'b0, 1'b0},
		'{snew_pkg::REQ_XFER,  snew_pkg::CMD_WRITE, 24'h000000, 16'h0000, 8'h00, 1'b0, 1'b0},
		'{snew_pkg::REQ_XFER,  snew_pkg::CMD_WRITE, 24'h000000, 16'h0000, 8'h00, 1'b0, 1'b0}
	};

	logic [7:0] area_values[] = '{8'd1, 8'd2, 8'd255, 8'd0, 8'd3, 8'd128};

	// Stimulus: reset, directed rows, then random operations
	initial begin
		xfer_res_t   typed_res;
		logic [23:0] a;
		logic [15:0] len;
		int          pick;
		int          area_sel;
		area_sel = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_area(8'd2);
		foreach (directed_rows[r]) begin
			send_beat(directed_rows[r].rt, directed_rows[r].cmd, directed_rows[r].addr,
				directed_rows[r].len, directed_rows[r].d, !directed_rows[r].typed);
			if (directed_rows[r].typed) begin
				typed_res = '{snew_pkg::ACT_DONE, 1'b0, 1'b0, area_chip(), 8'h00,
					directed_rows[r].st, 1'b1};
				pending_results.push_back(typed_res);
			end
		end
		service_op();
		for (int op = 0; op < RANDOM_OPS; op++) begin
			quiet = (op >= RANDOM_OPS - 5);
			force_busy = 1'b0;
			erased_fill = $urandom_range(0, 1);
			if (op % 5 == 0) begin
				write_area(area_values[area_sel % area_values.size()]);
				area_sel++;
			end
			a = 24'($urandom);
			len = 16'($urandom_range(1, 48));
			if (op == 2) begin
				// standalone erase that never leaves busy
				force_busy = 1'b1;
				send_beat(snew_pkg::REQ_HOST, snew_pkg::CMD_ERASE, a, 16'($urandom),
					8'($urandom), 1'b1);
			end else if (op == 5) begin
				// program times out twice: retry then fail
				force_busy = 1'b1;
				erased_fill = 1'b1;
				send_beat(snew_pkg::REQ_HOST, snew_pkg::CMD_WRITE, a, len, 8'($urandom), 1'b1);
			end else if (op == 8) begin
				// wrap past the top of the address space
				send_beat(snew_pkg::REQ_HOST, snew_pkg::CMD_WRITE, 24'hFFFFF0, 16'd32,
					8'($urandom), 1'b1);
			end else if (op == 11) begin
				// one byte, a full sector, then three bytes
				send_beat(snew_pkg::REQ_HOST, snew_pkg::CMD_WRITE, {a[23:12], 12'hFFF},
					16'd4100, 8'($urandom), 1'b1);
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < 12)
					send_beat(snew_pkg::REQ_HOST, snew_pkg::CMD_WRITE, a, len,
						8'($urandom), 1'b1);
				else if (pick < 50)
					send_beat(snew_pkg::REQ_HOST, snew_pkg::CMD_READ, a,
						16'($urandom_range(1, 300)), 8'($urandom), 1'b1);
				else if (pick < 65)
					send_beat(snew_pkg::REQ_HOST, snew_pkg::CMD_ERASE, a, 16'($urandom),
						8'($urandom), 1'b1);
				else if (pick < 75)
					send_beat(snew_pkg::REQ_HOST,
						$urandom_range(0, 1) ? CMD_UNKNOWN : snew_pkg::CMD_READ, a,
						16'd0, 8'($urandom), 1'b1);
				else
					repeat (4) send_beat(2'($urandom_range(1, 3)), 2'($urandom), a,
						16'($urandom), 8'($urandom), 1'b1);
			end
			service_op();
		end
		start <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0 && pending_results.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// Check each result beat against the oldest prediction
	always @(posedge clk) begin
		xfer_res_t want;
		if (arst_n && result_valid) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result beat: action %0d", action);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (action !== want.action) begin
					$error("action: expected %0d, got %0d", want.action, action);
					fail_count++;
				end
				if (select_before !== want.sel) begin
					$error("select_before: expected %0d, got %0d", want.sel, select_before);
					fail_count++;
				end
				if (deselect_after !== want.desel) begin
					$error("deselect_after: expected %0d, got %0d", want.desel, deselect_after);
					fail_count++;
				end
				if (chip !== want.chip) begin
					$error("chip: expected %0d, got %0d", want.chip, chip);
					fail_count++;
				end
				if (byte_value !== want.value) begin
					$error("byte_value: expected %0h, got %0h", want.value, byte_value);
					fail_count++;
				end
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					fail_count++;
				end
				if (last !== want.last) begin
					$error("last: expected %0d, got %0d", want.last, last);
					fail_count++;
				end
			end
		end
	end

	// Stop on a run of cycles with no beat in either direction
	always @(posedge clk) begin
		if ((start && !busy) || result_valid || !arst_n || psel)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end
endmodule

>>> spi_nor_erase_before_write_sequencer_core.f
+incdir+rtl
rtl/snew_pkg.sv
rtl/snew_datapath.sv
rtl/snew_ctrl.sv
rtl/spi_nor_erase_before_write_sequencer_core.sv
tb/spi_nor_erase_before_write_sequencer_core_tb.sv
